// ----- hdl/bra_pkg.sv -----
// ----------------------------------------------------------------------------
// bra_pkg
// Shared operation codes, field widths and the memory control group of the
// bit store with range-any query.
// ----------------------------------------------------------------------------
package bra_pkg;

    // operation codes carried on the input stream
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_GET   = 2'd1;
    localparam logic [1:0] MODE_SET   = 2'd2;
    localparam logic [1:0] MODE_ANY   = 2'd3;

    // fixed field widths
    localparam int MODE_W = 2;
    localparam int POS_W  = 12;
    localparam int END_W  = 13;

    // control strobes from the sequencer to the word memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } mem_ctl_t;

endpackage

// ----- hdl/bra_mem.sv -----
// ----------------------------------------------------------------------------
// bra_mem
// Word memory of the bit store: one synchronous read port, one write port,
// and one valid flop per word so that a clear empties every word at once.
// ----------------------------------------------------------------------------
module bra_mem
    import bra_pkg::*;
#(
    parameter int WORDS  = 128,
    parameter int WB     = 32,
    parameter int AW     = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mem_ctl_t      ctl,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [WB-1:0] wr_data,
    output logic [WB-1:0] rd_data
);

    logic [WB-1:0]    ram [WORDS];
    logic [WB-1:0]    q_reg;
    logic [WORDS-1:0] valid_reg;
    logic             vq_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= ram[rd_addr];
        end
    end

    // per-word valid flags, a word never written since clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                vq_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = vq_reg ? q_reg : '0;

endmodule

// ----- hdl/bra_ctrl.sv -----
// ----------------------------------------------------------------------------
// bra_ctrl
// Operation sequencer: decodes each input transfer, runs the read-modify-write
// of a set, the single read of a get and the word walk of a range query, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module bra_ctrl
    import bra_pkg::*;
#(
    parameter int STORE_BITS = 4096,
    parameter int WORD_BITS  = 32,
    parameter int WIDX       = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [POS_W-1:0]     position,
    input  logic [END_W-1:0]     range_end,
    input  logic                 new_bit,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 answer_bit,
    output logic                 out_of_range,
    output mem_ctl_t             mem_ctl,
    output logic [WIDX-1:0]      rd_addr,
    output logic [WIDX-1:0]      wr_addr,
    output logic [WORD_BITS-1:0] wr_data,
    input  logic [WORD_BITS-1:0] rd_data
);

    localparam int OW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int K  = END_W + 1 + OW;
    localparam int PW = END_W + K + 1 + WIDX;
    localparam logic [PW-1:0] RECIP =
        PW'(((64'd1 << K) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GETW = 3'd1;
    localparam logic [2:0] ST_SETW = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_RES  = 3'd4;

    // word index by reciprocal multiply, exact for all 13-bit values
    function automatic logic [PW-1:0] word_of(input logic [END_W-1:0] v);
        logic [PW-1:0] prod;
        prod = PW'(v) * RECIP;
        return prod >> K;
    endfunction

    // bit offset inside the word: constant multiply back and subtract
    function automatic logic [OW-1:0] off_of(input logic [END_W-1:0] v,
                                             input logic [PW-1:0]   q);
        logic [PW-1:0] diff;
        diff = PW'(v) - q * PW'(WORD_BITS);
        return diff[OW-1:0];
    endfunction

    logic [2:0]      state_reg, state_next;
    logic [WIDX-1:0] w_reg, w_next;
    logic [WIDX-1:0] last_reg, last_next;
    logic [OW-1:0]   b_reg, b_next;
    logic [OW-1:0]   hi_reg, hi_next;
    logic            nb_reg, nb_next;
    logic            first_reg, first_next;
    logic            rb_reg, rb_next;
    logic            ro_reg, ro_next;
    logic            ov_reg, ov_next;
    logic            ob_reg, ob_next;
    logic            oo_reg, oo_next;

    logic                 pos_over;
    logic                 end_over;
    logic [END_W-1:0]     end_clip;
    logic [END_W-1:0]     end_m1;
    logic                 empty;
    logic [PW-1:0]        pos_q;
    logic [PW-1:0]        endm1_q;
    logic [OW-1:0]        pos_off;
    logic [OW-1:0]        endm1_off;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] set_word;
    logic                 hit;

    // input decode: bounds, clipping and word/offset split
    assign pos_over  = 32'(position) >= STORE_BITS;
    assign end_over  = 32'(range_end) > STORE_BITS;
    assign end_clip  = end_over ? END_W'(STORE_BITS) : range_end;
    assign end_m1    = end_clip - END_W'(1);
    assign empty     = {1'b0, position} >= end_clip;
    assign pos_q     = word_of({1'b0, position});
    assign endm1_q   = word_of(end_m1);
    assign pos_off   = off_of({1'b0, position}, pos_q);
    assign endm1_off = off_of(end_m1, endm1_q);

    // mask of the bits of the current word that lie inside the range
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            scan_mask[i] = (!first_reg || (OW'(i) >= b_reg)) &&
                           ((w_reg != last_reg) || (OW'(i) <= hi_reg));
        end
    end

    assign hit = |(rd_data & scan_mask);

    // write-back word of a set
    always_comb
    begin
        set_word        = rd_data;
        set_word[b_reg] = nb_reg;
    end

    assign wr_data = set_word;
    assign wr_addr = w_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        last_next  = last_reg;
        b_next     = b_reg;
        hi_next    = hi_reg;
        nb_next    = nb_reg;
        first_next = first_reg;
        rb_next    = rb_reg;
        ro_next    = ro_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        oo_next    = oo_reg;
        mem_ctl    = '0;
        rd_addr    = w_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            mem_ctl.clr = 1'b1;
                        end
                        MODE_GET:
                        begin
                            if (pos_over)
                            begin
                                rb_next    = 1'b0;
                                ro_next    = 1'b1;
                                state_next = ST_RES;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = pos_q[WIDX-1:0];
                                b_next        = pos_off;
                                state_next    = ST_GETW;
                            end
                        end
                        MODE_SET:
                        begin
                            if (!pos_over)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = pos_q[WIDX-1:0];
                                w_next        = pos_q[WIDX-1:0];
                                b_next        = pos_off;
                                nb_next       = new_bit;
                                state_next    = ST_SETW;
                            end
                        end
                        default:
                        begin
                            rb_next = 1'b0;
                            ro_next = end_over || pos_over;
                            if (pos_over || empty)
                            begin
                                state_next = ST_RES;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = pos_q[WIDX-1:0];
                                w_next        = pos_q[WIDX-1:0];
                                b_next        = pos_off;
                                last_next     = endm1_q[WIDX-1:0];
                                hi_next       = endm1_off;
                                first_next    = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_GETW:
            begin
                rb_next    = rd_data[b_reg];
                ro_next    = 1'b0;
                state_next = ST_RES;
            end
            ST_SETW:
            begin
                mem_ctl.wr_en = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    rb_next    = 1'b1;
                    state_next = ST_RES;
                end
                else if (w_reg == last_reg)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = w_reg + WIDX'(1);
                    w_next        = w_reg + WIDX'(1);
                    first_next    = 1'b0;
                end
            end
            ST_RES:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ob_next    = rb_reg;
                    oo_next    = ro_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        last_reg  <= last_next;
        b_reg     <= b_next;
        hi_reg    <= hi_next;
        nb_reg    <= nb_next;
        first_reg <= first_next;
        rb_reg    <= rb_next;
        ro_reg    <= ro_next;
        ob_reg    <= ob_next;
        oo_reg    <= oo_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = ov_reg;
    assign answer_bit   = ob_reg;
    assign out_of_range = oo_reg;

endmodule

// ----- hdl/bitset_range_any_core.sv -----
// ----------------------------------------------------------------------------
// bitset_range_any_core
// Bit store kept as words in a synchronous memory; clear, get, set and
// range-any operations, one per input transfer.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                     tuser
//  s_axis    in   position, range_end, new_bit (32 bits) mode (2 bits)
//  m_axis    out  answer_bit (8 bits)                    out_of_range (1 bit)
//
//  clear is done in idle; set reads the word, then writes it back; get reads
//  the word, then loads the bit (get beyond the store reads none). range any
//  reads up to STORE_WORDS words, one per cycle from the memory read port.
//  rst_n clears the control state and the per-word valid flags, so the store
//  reads as all zeros right after reset with no clearing pass.
//  a result waits in the output register while the next transfer is taken;
//  a new result is only loaded once that register is free.
// ----------------------------------------------------------------------------
module bitset_range_any_core
    import bra_pkg::*;
#(
    parameter int STORE_BITS = 4096,
    parameter int WORD_BITS  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // position[11:0], range_end[24:12], new_bit[25]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // answer_bit[0]
    output logic        m_axis_tuser    // out_of_range[0]
);

    localparam int STORE_WORDS = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    mem_ctl_t             mem_ctl;
    logic [WIDX-1:0]      rd_addr;
    logic [WIDX-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] rd_data;
    logic                 answer_bit;

    // operation sequencer
    bra_ctrl #(
        .STORE_BITS (STORE_BITS),
        .WORD_BITS  (WORD_BITS),
        .WIDX       (WIDX)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .mode         (s_axis_tuser),
        .position     (s_axis_tdata[11:0]),
        .range_end    (s_axis_tdata[24:12]),
        .new_bit      (s_axis_tdata[25]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .answer_bit   (answer_bit),
        .out_of_range (m_axis_tuser),
        .mem_ctl      (mem_ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_data      (rd_data)
    );

    // word store
    bra_mem #(
        .WORDS (STORE_WORDS),
        .WB    (WORD_BITS),
        .AW    (WIDX)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // result packing, upper bits zero
    assign m_axis_tdata = {7'd0, answer_bit};

endmodule

// ----- hdl/bra_checker.sv -----
// ----------------------------------------------------------------------------
// bra_port_checks
// Port-level checks of the bit store core over time, bound to the top level.
// ----------------------------------------------------------------------------
module bra_port_checks
    import bra_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // clear and set never produce a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser == MODE_CLEAR || s_axis_tuser == MODE_SET)
            |=> !$rose(m_axis_tvalid))
        else $error("result after clear or set");

    // a query keeps the input closed while it runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser == MODE_GET || s_axis_tuser == MODE_ANY)
            |=> !s_axis_tready)
        else $error("input open during query");

    // a new result only comes out of a busy cycle
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind bitset_range_any_core bra_port_checks u_bra_port_checks (.*);
